>>> rtl/pvsc_pkg.sv
package pvsc_pkg;

  // ADC resolution; the sample field carries AdcW bits, AdcBits of them are used
  localparam int AdcBits = 12;
  localparam int AdcW    = 12;

  localparam int RefW    = 13;
  localparam int ResW    = 20;
  localparam int DutyW   = 10;
  localparam int ClkW    = 30;
  localparam int CapW    = 32;
  localparam int MvW     = 16;
  localparam int StateW  = 4;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 30;

  // divider operand widths
  localparam int SumW  = ResW + 1;
  localparam int P1W   = AdcBits + RefW;
  localparam int NumW  = P1W + SumW;
  localparam int DenW  = AdcBits + ResW;
  localparam int DutyNumW = CapW + DutyW;
  localparam int DivNW = (NumW > DutyNumW) ? NumW : DutyNumW;
  localparam int DivDW = (DenW > CapW) ? DenW : CapW;
  localparam int DivQW = 30;
  localparam int DivCntW = $clog2(DivNW + 1);

  localparam logic [MvW:0]   MvInvalidAbove = 17'd13000;
  localparam logic [MvW:0]   MvS1Min        = 17'd11000;
  localparam logic [MvW:0]   MvS1Band       = 17'd10000;
  localparam logic [MvW:0]   MvS2Min        = 17'd8000;
  localparam logic [MvW:0]   MvS2Band       = 17'd7000;
  localparam logic [MvW:0]   MvS3Min        = 17'd4000;
  localparam logic [MvW:0]   MvLowMax       = 17'd1000;
  localparam logic [DutyW-1:0] DutyFull     = 10'd1000;

  typedef enum logic [StateW-1:0] {
    ST_UNKNOWN = 4'd0,
    ST_INVALID = 4'd1,
    ST_S0      = 4'd2,
    ST_S1      = 4'd3,
    ST_S1P     = 4'd4,
    ST_S2      = 4'd5,
    ST_S2P     = 4'd6,
    ST_S3      = 4'd7,
    ST_S3P     = 4'd8,
    ST_S4      = 4'd9
  } pilot_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_MV   = 3'd0,
    CFG_UPPER    = 3'd1,
    CFG_LOWER    = 3'd2,
    CFG_DUTY     = 3'd3,
    CFG_CAP_CLK  = 3'd4
  } cfg_idx_e;

endpackage

>>> rtl/pvsc_in_if.sv
interface pvsc_in_if import pvsc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [AdcW-1:0] adc_sample;
  logic            sample_fresh;
  logic            diode_level;
  logic [CapW-1:0] capture_period;
  logic [CapW-1:0] capture_pulse;
  logic            capture_fresh;

  modport source (output valid, adc_sample, sample_fresh, diode_level, capture_period,
                  capture_pulse, capture_fresh, input ready);
  modport sink (input valid, adc_sample, sample_fresh, diode_level, capture_period,
                capture_pulse, capture_fresh, output ready);
endinterface

>>> rtl/pvsc_out_if.sv
interface pvsc_out_if import pvsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              no_sample;
  logic [MvW-1:0]    pilot_mv;
  logic [StateW-1:0] pilot_state;
  logic              diode_seen;
  logic              feedback_ok;
  logic [ClkW-1:0]   feedback_freq;
  logic [DutyW-1:0]  feedback_duty;

  modport source (output valid, no_sample, pilot_mv, pilot_state, diode_seen,
                  feedback_ok, feedback_freq, feedback_duty, input ready);
  modport sink (input valid, no_sample, pilot_mv, pilot_state, diode_seen,
                feedback_ok, feedback_freq, feedback_duty, output ready);
endinterface

>>> rtl/pvsc_serdiv.sv
module pvsc_serdiv import pvsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DivNW-1:0]  num_i,
  input  logic [DivDW-1:0]  den_i,
  output logic              done_o,
  output logic [DivQW-1:0]  quo_o,
  output logic              ovf_o
);

  logic [DivNW-1:0]   num_q;
  logic [DivDW-1:0]   den_q;
  logic [DivDW-1:0]   rem_q;
  logic [DivQW-1:0]   quo_q;
  logic               ovf_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DivDW:0] trial;
  logic [DivDW:0] diff;
  logic           ge;

  // restoring division, one quotient bit a cycle, numerator MSB first
  assign trial = {rem_q, num_q[DivNW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivNW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[DivNW-2:0], 1'b0};
      rem_q <= ge ? diff[DivDW-1:0] : trial[DivDW-1:0];
      quo_q <= {quo_q[DivQW-2:0], ge};
      // any bit pushed out of the top means the quotient does not fit
      ovf_q <= ovf_q | quo_q[DivQW-1];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

>>> rtl/pilot_voltage_state_classifier_top.sv
// Control pilot voltage state classifier.
//
// One word in on in_i gives one word out on out_o. An input word carries an
// ADC sample with its freshness flag, the diode pin level and one PWM capture
// (period, pulse, fresh). The result gives the pilot voltage in mV, the pilot
// state code, the diode copy and the feedback frequency and duty. Registers
// are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user writes them
// only while idle, and the block itself does not enforce it.
//
// A fresh sample goes from accept to S_MUL, which starts the dividers with the
// second product, then to S_DIV, where three bit-serial dividers run side by
// side (the mV scaling numerator sets their width), then to S_FIN, which loads
// the output register. A stale sample skips the dividers and goes straight to
// S_FIN, which loads its no-sample word. One word is in work at a time, so no
// new word is taken until the last has left S_FIN; in_i.ready is high when the
// datapath is free, even while a finished word still waits in the output
// register. A stalled out_o holds its word; the next result waits behind it.
// Reset loads the default register values, clears the remembered pilot state
// to unknown and empties the output register.
module pilot_voltage_state_classifier_top import pvsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pvsc_in_if.sink             in_i,
  pvsc_out_if.source          out_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } fsm_e;

  fsm_e state_q, state_d;

  logic [RefW-1:0]  ref_q;
  logic [ResW-1:0]  upper_q;
  logic [ResW-1:0]  lower_q;
  logic [DutyW-1:0] duty_q;
  logic [ClkW-1:0]  clk_hz_q;
  pilot_state_e     rem_q;

  logic             fresh_q;
  logic             diode_q;
  logic             cap_fresh_q;
  logic [CapW-1:0]  period_q;
  logic [CapW-1:0]  pulse_q;
  logic [P1W-1:0]   p1_q;

  logic                out_valid_q;
  logic                out_no_sample_q;
  logic [MvW-1:0]      out_mv_q;
  logic [StateW-1:0]   out_state_q;
  logic                out_diode_q;
  logic                out_fb_ok_q;
  logic [ClkW-1:0]     out_hz_q;
  logic [DutyW-1:0]    out_duty_q;

  logic in_acc;
  logic out_free;
  logic fin_load;

  logic [SumW-1:0]     sum;
  logic [DenW-1:0]     den;
  logic [AdcBits-1:0]  sample;
  logic                div_start;
  logic                mv_done, hz_done, dt_done;
  logic [DivQW-1:0]    mv_q, hz_q, dt_q;
  logic                mv_ovf, hz_ovf, dt_ovf;

  logic              pwm;
  logic              mv_sat;
  logic [MvW-1:0]    mv_val;
  pilot_state_e      st_new;
  pilot_state_e      st_base;
  logic              fb_ok;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign fin_load = (state_q == S_FIN) && out_free;
  assign in_i.ready = (state_q == S_IDLE);
  assign sample   = AdcBits'(in_i.adc_sample);

  function automatic pilot_state_e base_of(pilot_state_e s);
    pilot_state_e r;
    unique case (s)
      ST_S1P:  r = ST_S1;
      ST_S2P:  r = ST_S2;
      ST_S3P:  r = ST_S3;
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic pilot_state_e primed(pilot_state_e s, logic pw);
    pilot_state_e r;
    r = s;
    if (pw) begin
      unique case (s)
        ST_S1:   r = ST_S1P;
        ST_S2:   r = ST_S2P;
        ST_S3:   r = ST_S3P;
        default: r = s;
      endcase
    end
    return r;
  endfunction

  function automatic pilot_state_e classify(logic sat, logic [MvW-1:0] mv,
                                            logic [DutyW-1:0] duty, logic pw,
                                            pilot_state_e prev);
    pilot_state_e pb;
    pilot_state_e r;
    logic [MvW:0] v;
    pb = base_of(prev);
    v  = {1'b0, mv};
    priority if (sat || v > MvInvalidAbove) begin
      r = ST_INVALID;
    end else if (v >= MvS1Min) begin
      r = primed(ST_S1, pw);
    end else if (v > MvS1Band) begin
      r = (pb == ST_S1 || pb == ST_S2) ? primed(pb, pw) : ST_UNKNOWN;
    end else if (v >= MvS2Min) begin
      r = primed(ST_S2, pw);
    end else if (v > MvS2Band) begin
      r = (pb == ST_S2 || pb == ST_S3) ? primed(pb, pw) : ST_UNKNOWN;
    end else if (v >= MvS3Min) begin
      r = primed(ST_S3, pw);
    end else if (v <= MvLowMax) begin
      if (duty == '0) begin
        r = ST_S4;
      end else begin
        r = pw ? ST_INVALID : ST_S0;
      end
    end else begin
      r = ST_INVALID;
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= RefW'(3300);
      upper_q  <= ResW'(100000);
      lower_q  <= ResW'(22000);
      duty_q   <= DutyW'(1000);
      clk_hz_q <= ClkW'(1000000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REF_MV:  ref_q    <= cfg_data_i[RefW-1:0];
        CFG_UPPER:   upper_q  <= cfg_data_i[ResW-1:0];
        CFG_LOWER:   lower_q  <= cfg_data_i[ResW-1:0];
        CFG_DUTY:    duty_q   <= cfg_data_i[DutyW-1:0];
        CFG_CAP_CLK: clk_hz_q <= cfg_data_i[ClkW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = in_i.sample_fresh ? S_MUL : S_FIN;
      S_MUL:  state_d = S_DIV;
      S_DIV:  if (mv_done) state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture the word and take the first product
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fresh_q     <= in_i.sample_fresh;
      diode_q     <= in_i.diode_level;
      cap_fresh_q <= in_i.capture_fresh;
      period_q    <= in_i.capture_period;
      pulse_q     <= in_i.capture_pulse;
      p1_q        <= P1W'(sample) * P1W'(ref_q);
    end
  end

  assign sum       = {1'b0, upper_q} + {1'b0, lower_q};
  // max_code * lower without a multiplier
  assign den       = {lower_q, {AdcBits{1'b0}}} - DenW'(lower_q);
  assign div_start = (state_q == S_MUL);

  pvsc_serdiv u_div_mv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (DivNW'(NumW'(p1_q) * NumW'(sum))),
    .den_i   (DivDW'(den)),
    .done_o  (mv_done),
    .quo_o   (mv_q),
    .ovf_o   (mv_ovf)
  );

  pvsc_serdiv u_div_hz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (DivNW'(clk_hz_q)),
    .den_i   (DivDW'(period_q)),
    .done_o  (hz_done),
    .quo_o   (hz_q),
    .ovf_o   (hz_ovf)
  );

  pvsc_serdiv u_div_dt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (DivNW'(DutyNumW'(pulse_q) * DutyNumW'(DutyFull))),
    .den_i   (DivDW'(period_q)),
    .done_o  (dt_done),
    .quo_o   (dt_q),
    .ovf_o   (dt_ovf)
  );

  assign pwm    = (duty_q != '0) && (duty_q < DutyFull);
  assign mv_sat = (lower_q == '0) || mv_ovf || (|mv_q[DivQW-1:MvW]);
  assign mv_val = mv_sat ? {MvW{1'b1}} : mv_q[MvW-1:0];
  assign st_new = classify(mv_sat, mv_val, duty_q, pwm, rem_q);
  assign st_base = base_of(st_new);
  assign fb_ok  = cap_fresh_q && (period_q != '0) && (pulse_q <= period_q) && pwm;

  // remember the last stable s1/s2/s3 result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= ST_UNKNOWN;
    end else if (fin_load && fresh_q &&
                 (st_base == ST_S1 || st_base == ST_S2 || st_base == ST_S3)) begin
      rem_q <= st_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_no_sample_q <= !fresh_q;
      out_mv_q        <= fresh_q ? mv_val : '0;
      out_state_q     <= fresh_q ? st_new : ST_UNKNOWN;
      out_diode_q     <= fresh_q && diode_q;
      out_fb_ok_q     <= fresh_q && fb_ok;
      out_hz_q        <= (fresh_q && fb_ok) ? hz_q[ClkW-1:0] : '0;
      out_duty_q      <= (fresh_q && fb_ok) ? dt_q[DutyW-1:0] : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.no_sample     = out_no_sample_q;
  assign out_o.pilot_mv      = out_mv_q;
  assign out_o.pilot_state   = out_state_q;
  assign out_o.diode_seen    = out_diode_q;
  assign out_o.feedback_ok   = out_fb_ok_q;
  assign out_o.feedback_freq = out_hz_q;
  assign out_o.feedback_duty = out_duty_q;

`ifndef SYNTHESIS
  a_stale_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_i.sample_fresh |=> state_q == S_FIN)
    else $error("stale word did not bypass the dividers");

  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_no_sample_q |-> out_mv_q == '0 && out_state_q == ST_UNKNOWN &&
    !out_fb_ok_q && out_hz_q == '0 && out_duty_q == '0)
    else $error("no-sample word carries nonzero fields");

  a_rem_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == ST_UNKNOWN || rem_q == ST_S1 || rem_q == ST_S1P || rem_q == ST_S2 ||
    rem_q == ST_S2P || rem_q == ST_S3 || rem_q == ST_S3P)
    else $error("remembered state is not a stable band state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_done |-> state_q == S_DIV && hz_done && dt_done)
    else $error("divider finished outside the divide phase");

  a_fb_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load && fresh_q && fb_ok |-> !hz_ovf && !dt_ovf)
    else $error("feedback quotient overflowed");
`endif

endmodule
